// File: rtl/core/qfsd_pkg.sv
// Shared types, constants and the full-step transition table for the
// quadrature full-step speed decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qfsd_pkg;

  // Entry coding of the transition table: low nibble next phase,
  // bit 4 clockwise step, bit 5 counter-clockwise step.
  localparam logic [7:0] STEP_CW  = 8'h10;
  localparam logic [7:0] STEP_CCW = 8'h20;
  localparam logic [7:0] STEP_ANY = 8'h30;
  localparam logic [7:0] NEXT_MSK = 8'h0f;

  localparam logic [7:0] SENS_RESET = 8'd100;

  localparam logic [2:0] MAG_FAST = 3'd3;
  localparam logic [2:0] MAG_MED  = 3'd2;
  localparam logic [2:0] MAG_SLOW = 3'd1;

  typedef logic [2:0] phase_t;

  // One pin sample as held in the input register
  typedef struct packed {
    logic        pin_a;
    logic        pin_b;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    phase_t next;
    logic   cw;
    logic   ccw;
  } step_entry_t;

  // Rows: phase, columns: pin code {pin_a, pin_b}.
  // The unused phase code behaves like the start phase.
  localparam logic [7:0] STEP_TABLE [8][4] = '{
    '{8'h00, 8'h02, 8'h04, 8'h00},
    '{8'h03, 8'h00, 8'h01, 8'h00 | STEP_CW},
    '{8'h03, 8'h02, 8'h00, 8'h00},
    '{8'h03, 8'h02, 8'h01, 8'h00},
    '{8'h06, 8'h00, 8'h04, 8'h00},
    '{8'h06, 8'h05, 8'h00, 8'h00 | STEP_CCW},
    '{8'h06, 8'h05, 8'h04, 8'h00},
    '{8'h00, 8'h02, 8'h04, 8'h00}
  };

  function automatic step_entry_t step_lookup(input phase_t ph, input logic [1:0] code);
    logic [7:0]  raw;
    logic [7:0]  nxt;
    step_entry_t e;
    raw    = STEP_TABLE[ph][code];
    nxt    = raw & NEXT_MSK;
    e.next = nxt[2:0];
    e.cw   = (raw & STEP_ANY) == STEP_CW;
    e.ccw  = (raw & STEP_ANY) == STEP_CCW;
    return e;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/qfsd_in_reg.sv
// Input register of the quadrature full-step speed decoder: holds one
// accepted pin sample until the decode stage takes it. Uses qfsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qfsd_in_reg
  import qfsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_pin_a,
  input  wire logic        in_pin_b,
  input  wire logic [31:0] in_now_ms,
  input  wire logic        take,
  output logic             smp_valid,
  output sample_t          smp
);

  logic    valid_r, valid_nxt;
  sample_t smp_r;

  // Free when empty or when the held sample moves on this cycle
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r <= '{pin_a: in_pin_a, pin_b: in_pin_b, now_ms: in_now_ms};
    end
  end

  assign smp_valid = valid_r;
  assign smp       = smp_r;

endmodule

`default_nettype wire

// File: rtl/core/qfsd_core.sv
// Decode stage: phase and last-step-time state, table transition, speed
// compare and the result register. Uses qfsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qfsd_core
  import qfsd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       smp_valid,
  input  sample_t         smp,
  output logic            take,
  input  wire logic [7:0] sensitivity,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_rotation
);

  localparam int NOW_W = (TIME_BITS < 32) ? TIME_BITS : 32;

  phase_t                 phase_r, phase_nxt;
  logic [TIME_BITS-1:0]   last_r, last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             rot_r, rot_nxt;

  step_entry_t            entry;
  logic [TIME_BITS-1:0]   now_t;
  logic [TIME_BITS-1:0]   elapsed;
  logic [TIME_BITS-1:0]   sens_full;
  logic [TIME_BITS-1:0]   sens_half;
  logic [2:0]             mag;
  logic                   fire;

  assign take = !out_valid_r || out_ready;
  assign fire = smp_valid && take;

  assign entry = step_lookup(phase_r, {smp.pin_a, smp.pin_b});

  always_comb begin
    now_t              = '0;
    now_t[NOW_W-1:0]   = smp.now_ms[NOW_W-1:0];
    sens_full          = '0;
    sens_full[7:0]     = sensitivity;
    sens_half          = '0;
    sens_half[6:0]     = sensitivity[7:1];
  end

  // Elapsed time wraps at TIME_BITS, the width of now_t and last_r
  assign elapsed = now_t - last_r;

  always_comb begin
    priority if (elapsed < sens_half) begin
      mag = MAG_FAST;
    end else if (elapsed < sens_full) begin
      mag = MAG_MED;
    end else begin
      mag = MAG_SLOW;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    rot_nxt       = rot_r;
    if (fire) begin
      phase_nxt     = entry.next;
      out_valid_nxt = 1'b1;
      rot_nxt       = '0;
      if (entry.cw || entry.ccw) begin
        last_nxt = now_t;
        rot_nxt  = entry.ccw ? (3'd0 - mag) : mag;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_rotation = rot_r;

endmodule

`default_nettype wire

// File: rtl/core/quadrature_full_step_speed_decoder.sv
// Quadrature full-step speed decoder, top level.
// Channels: in_* carries one sample (in_pin_a, in_pin_b, in_now_ms) per
// transaction under in_valid/in_ready; out_* returns one signed step,
// out_rotation in -3..+3 (0 = no step), per input transaction.
// Config: APB-style cfg_* port, register 0 at byte address 0 is the 8-bit
// sensitivity (reset 100); 0 turns speed scaling off.
// Throughput: one sample per cycle while out_ready is high; the input
// register and the result register each pass a transaction on while
// taking the next. The decode path is one table lookup, a TIME_BITS
// subtract and two compares between those registers.
// Reset (synchronous, rst_n low): phase to the rest state, last step time
// to 0, sensitivity to 100, both pipeline stages empty.
// Stall: with out_ready low the result holds; the input register then
// fills and in_ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_full_step_speed_decoder
  import qfsd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_pin_a,
  input  wire logic        in_pin_b,
  input  wire logic [31:0] in_now_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_rotation,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic REG_SENSITIVITY = 1'b0;

  logic       sens_sel, unused_sens;
  logic [7:0] sensitivity_r;
  logic       cfg_wr;
  logic       take;
  logic       smp_valid;
  sample_t    smp;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign sens_sel   = cfg_paddr[2] == REG_SENSITIVITY;
  assign unused_sens = ^cfg_paddr[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensitivity_r <= SENS_RESET;
    end else if (cfg_wr && sens_sel) begin
      sensitivity_r <= cfg_pwdata[7:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (sens_sel && !unused_sens || sens_sel) begin
      cfg_prdata[7:0] = sensitivity_r;
    end
  end

  qfsd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pin_a  (in_pin_a),
    .in_pin_b  (in_pin_b),
    .in_now_ms (in_now_ms),
    .take      (take),
    .smp_valid (smp_valid),
    .smp       (smp)
  );

  qfsd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .smp_valid    (smp_valid),
    .smp          (smp),
    .take         (take),
    .sensitivity  (sensitivity_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rotation (out_rotation)
  );

endmodule

`default_nettype wire

// File: rtl/core/qfsd_checker.sv
// Port-level checks for the quadrature full-step speed decoder, attached
// to the top level by the bind statement at the end of this file.
`timescale 1ns / 1ps
`default_nettype none

module qfsd_sva_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_rotation
);

  // Empty pipeline after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rotation))
    else $error("stalled result changed");

  // Magnitude never exceeds three
  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rotation != 3'b100)
    else $error("rotation out of range");

  // With no result waiting the block takes a sample
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // An accepted sample always yields a result once it has passed the input
  // register and the result register, unless the output is stalled in between
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (!out_valid || out_ready) ##1 (!out_valid || out_ready)
    |=> out_valid)
    else $error("accepted sample produced no result");

endmodule

bind quadrature_full_step_speed_decoder qfsd_sva_checker u_qfsd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_rotation (out_rotation)
);

`default_nettype wire
